// ===== design/kcl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keypad code lock.
// No dependencies.
package kcl_pkg;

   localparam int KEY_W = 8;

   localparam logic [KEY_W-1:0] EMPTY_KEY = 8'h66;
   localparam logic [KEY_W-1:0] STAR_KEY  = 8'h2A;
   localparam logic [KEY_W-1:0] HASH_KEY  = 8'h23;

   localparam logic [1:0] MODE_KEY   = 2'd0;
   localparam logic [1:0] MODE_STORE = 2'd1;
   localparam logic [1:0] MODE_CHECK = 2'd2;

   typedef enum logic [2:0] {
      ST_NOT_FILLED = 3'd0,
      ST_FILLED     = 3'd1,
      ST_SET_MODE   = 3'd2,
      ST_VALID      = 3'd3,
      ST_INVALID    = 3'd4
   } status_type;

endpackage

// ===== design/keypad_code_lock.sv =====
`timescale 1ns / 1ps
// Keypad code lock: entry buffer, stored code list and status logic.
// Depends on kcl_pkg.
//
// Usage:
//   req_ channel carries one word per keypad event: req_mode selects key press,
//   store entered code or check entered code; req_key is the key character
//   (0x66 = key released), looked at only for key presses.
//   rsp_ channel returns exactly one word per request: rsp_status.
//   A request is taken into an input register; when the result register
//   can advance, it is evaluated against the entry buffer and stored codes,
//   which it updates, and the result register is loaded. Throughput is one
//   word per cycle while rsp_stall is low, set by the single evaluation stage.
//   When rsp_stall holds the result, the input register still fills, and
//   req_stall rises only once both registers are occupied.
//   Reset (synchronous, active high) empties the entry buffer, sets every
//   stored code to all 0x66 and drops both valid flags.
module keypad_code_lock
   import kcl_pkg::*;
#(
   parameter int CODE_LEN   = 4,
   parameter int CODE_SLOTS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status
);

   typedef logic [CODE_LEN-1:0][KEY_W-1:0] code_type;

   localparam code_type EMPTY_CODE = {CODE_LEN{EMPTY_KEY}};

   logic             in_valid_ff;
   logic [1:0]       in_mode_ff;
   logic [KEY_W-1:0] in_key_ff;

   code_type   entry_ff, entry_in;
   code_type   codes_ff [CODE_SLOTS];
   code_type   codes_in [CODE_SLOTS];
   logic       codes_we;

   logic       rsp_valid_ff;
   status_type rsp_status_ff, rsp_status_in;

   logic       advance;
   logic       do_item;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign do_item   = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      code_type filled;
      logic     found;
      logic     last;
      logic     ok;
      logic     hit;
      filled = entry_ff;
      found  = 1'b0;
      last   = 1'b0;
      ok     = 1'b1;
      hit    = 1'b0;
      for (int i = 0; i < CODE_LEN; i++) begin
         if (!found && entry_ff[i] == EMPTY_KEY) begin
            filled[i] = in_key_ff;
            found     = 1'b1;
            last      = (i == CODE_LEN - 1);
         end
         if (entry_ff[i] == STAR_KEY || entry_ff[i] == HASH_KEY ||
             entry_ff[i] == EMPTY_KEY) begin
            ok = 1'b0;
         end
      end
      for (int s = 0; s < CODE_SLOTS; s++) begin
         if (codes_ff[s] == entry_ff) begin
            hit = 1'b1;
         end
      end
      codes_in[0] = entry_ff;
      for (int s = 1; s < CODE_SLOTS; s++) begin
         codes_in[s] = codes_ff[s-1];
      end

      entry_in      = entry_ff;
      codes_we      = 1'b0;
      rsp_status_in = ST_NOT_FILLED;
      case (in_mode_ff)
         MODE_KEY: begin
            if (in_key_ff != EMPTY_KEY) begin
               if (found && last) begin
                  entry_in      = filled;
                  rsp_status_in = ST_FILLED;
               end else if (filled[0] == STAR_KEY && filled[1] == STAR_KEY) begin
                  entry_in      = EMPTY_CODE;
                  rsp_status_in = ST_SET_MODE;
               end else begin
                  entry_in = filled;
               end
            end
         end
         MODE_STORE: begin
            entry_in      = EMPTY_CODE;
            codes_we      = ok;
            rsp_status_in = ok ? ST_VALID : ST_INVALID;
         end
         MODE_CHECK: begin
            entry_in      = EMPTY_CODE;
            rsp_status_in = (ok && hit) ? ST_VALID : ST_INVALID;
         end
         default: begin
            rsp_status_in = ST_NOT_FILLED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_mode_ff <= req_mode;
         in_key_ff  <= req_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         entry_ff     <= EMPTY_CODE;
         for (int s = 0; s < CODE_SLOTS; s++) begin
            codes_ff[s] <= EMPTY_CODE;
         end
      end else begin
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (do_item) begin
            entry_ff <= entry_in;
            if (codes_we) begin
               for (int s = 0; s < CODE_SLOTS; s++) begin
                  codes_ff[s] <= codes_in[s];
               end
            end
         end
      end
      if (do_item) begin
         rsp_status_ff <= rsp_status_in;
      end
   end

   // entry buffer always fills from the low end: no key after an empty slot
   logic entry_gap;
   always_comb begin
      logic seen_empty;
      seen_empty = 1'b0;
      entry_gap  = 1'b0;
      for (int i = 0; i < CODE_LEN; i++) begin
         if (entry_ff[i] == EMPTY_KEY) begin
            seen_empty = 1'b1;
         end else if (seen_empty) begin
            entry_gap = 1'b1;
         end
      end
   end

   a_entry_contiguous: assert property (@(posedge clock) disable iff (reset)
      !entry_gap)
      else $error("entry buffer has a key after an empty slot");

   a_store_check_clears: assert property (@(posedge clock) disable iff (reset)
      (do_item && (in_mode_ff == MODE_STORE || in_mode_ff == MODE_CHECK))
      |=> entry_ff == EMPTY_CODE)
      else $error("entry buffer not emptied after store or check");

   a_codes_stable: assert property (@(posedge clock) disable iff (reset)
      !(do_item && codes_we) |=> codes_ff[0] == $past(codes_ff[0]))
      else $error("stored code changed without a valid store");

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      do_item |=> rsp_valid_ff)
      else $error("processed word produced no result");

endmodule
